/* sv/tta_pkg.sv */
// tta_pkg: shared constants, register codes and types for the tensor transpose
// address generator. No dependencies; every other file imports this package.

package tta_pkg;

  // default parameter values for the top level
  localparam int DEF_MAX_RANK   = 6;
  localparam int DEF_ADDR_WIDTH = 32;
  localparam int DEF_ELEM_WIDTH = 64;

  // fixed field widths at the ports
  localparam int ELEM_PORT_W  = 64;
  localparam int INDEX_PORT_W = 32;
  localparam int EXT_W        = 16;
  localparam int PERM_FW      = 3;
  localparam int RANK_REG_W   = 3;
  localparam int PERM_REG_W   = 18;
  localparam int NUM_DIM_REGS = 6;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 5;

  // register reset values
  localparam logic [RANK_REG_W-1:0] RANK_RESET = RANK_REG_W'(2);
  localparam logic [PERM_REG_W-1:0] PERM_RESET = PERM_REG_W'(1);
  localparam logic [EXT_W-1:0]      DIM_RESET  = EXT_W'(1);

  // register index, word address bits [4:2]
  typedef enum logic [2:0] {
    REG_RANK,
    REG_PERM,
    REG_DIM0,
    REG_DIM1,
    REG_DIM2,
    REG_DIM3,
    REG_DIM4,
    REG_DIM5
  } reg_idx_t;

  // stride setup sequencer
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_STRIDE,
    SEQ_DELTA
  } seq_state_t;

  // status from the setup unit to the streaming path
  typedef struct packed {
    logic busy;
    logic oversize;
  } setup_stat_t;

  // one result beat
  typedef struct packed {
    logic [INDEX_PORT_W-1:0] out_index;
    logic [ELEM_PORT_W-1:0]  moved_value;
    logic                    last_element;
    logic                    size_error;
  } result_t;

endpackage

/* sv/tta_ifs.sv */
// tta_elem_if and tta_result_if: valid/ready channels for element beats in
// and result beats out. Depends on tta_pkg for the field widths.

interface tta_elem_if;
  import tta_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ELEM_PORT_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

interface tta_result_if;
  import tta_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [INDEX_PORT_W-1:0] out_index;
  logic [ELEM_PORT_W-1:0]  moved_value;
  logic                    last_element;
  logic                    size_error;

  modport source (output valid, output out_index, output moved_value,
                  output last_element, output size_error, input ready);
  modport sink   (input valid, input out_index, input moved_value,
                  input last_element, input size_error, output ready);
endinterface

/* sv/tta_stride_unit.sv */
// tta_stride_unit: sequencer that derives per-dimension address steps and the
// oversize flag from the configuration. Uses tta_pkg.

module tta_stride_unit #(
  parameter int MAX_RANK   = tta_pkg::DEF_MAX_RANK,
  parameter int ADDR_WIDTH = tta_pkg::DEF_ADDR_WIDTH,
  parameter int DIM_W      = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1,
  parameter int RANK_W     = $clog2(MAX_RANK + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [RANK_W-1:0]           rank,
  input  logic [tta_pkg::PERM_FW-1:0] perm_field [MAX_RANK],
  input  logic [tta_pkg::EXT_W-1:0]   ext        [MAX_RANK],
  output logic [ADDR_WIDTH-1:0]       delta      [MAX_RANK],
  output tta_pkg::setup_stat_t        stat
);
  import tta_pkg::*;

  localparam int CMP_W  = (RANK_W > PERM_FW) ? RANK_W : PERM_FW;
  localparam int PROD_W = ADDR_WIDTH + EXT_W;
  localparam int CNT_W  = ADDR_WIDTH + 1;
  localparam int CPRD_W = CNT_W + EXT_W;
  localparam logic [CPRD_W-1:0] LIM = CPRD_W'(1) << ADDR_WIDTH;

  seq_state_t state, state_next;

  logic [DIM_W-1:0]      idx;
  logic [ADDR_WIDTH-1:0] s;
  logic [CNT_W-1:0]      cnt;
  logic [ADDR_WIDTH-1:0] acc;
  logic [ADDR_WIDTH-1:0] in_stride [MAX_RANK];
  logic                  oversize;

  logic                  perm_ok;
  logic [2**PERM_FW-1:0] seen;
  logic [DIM_W-1:0]      p_eff [MAX_RANK];
  logic [EXT_W-1:0]      ext_sel;
  logic [PROD_W-1:0]     prod_s;
  logic [CPRD_W-1:0]     prod_c;
  logic [PROD_W-1:0]     prod_d;

  // permutation check, fall back to reverse order
  always_comb begin
    seen    = '0;
    perm_ok = 1'b1;
    for (int j = 0; j < MAX_RANK; j++) begin
      if (j < rank) begin
        if (CMP_W'(perm_field[j]) >= CMP_W'(rank) || seen[perm_field[j]]) begin
          perm_ok = 1'b0;
        end else begin
          seen[perm_field[j]] = 1'b1;
        end
      end
    end
    for (int j = 0; j < MAX_RANK; j++) begin
      if (perm_ok) begin
        p_eff[j] = DIM_W'(perm_field[j]);
      end else begin
        p_eff[j] = DIM_W'(int'(rank) - j - 1);
      end
    end
  end

  // shared multipliers
  assign ext_sel = ext[p_eff[idx]];
  assign prod_s  = s * ext_sel;
  assign prod_c  = cnt * ext_sel;
  assign prod_d  = in_stride[idx] * (ext[idx] - EXT_W'(1));

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state, a new write restarts the sweep
  always_comb begin
    state_next = state;
    case (state)
      SEQ_LOAD:   state_next = SEQ_STRIDE;
      SEQ_STRIDE: if (idx == '0) state_next = SEQ_DELTA;
      SEQ_DELTA:  if (idx == '0) state_next = SEQ_IDLE;
      default:    state_next = SEQ_IDLE;
    endcase
    if (start) begin
      state_next = SEQ_LOAD;
    end
  end

  // stride pass from the innermost output dimension, then step pass
  always_ff @(posedge clk) begin
    case (state)
      SEQ_LOAD: begin
        idx <= DIM_W'(rank - RANK_W'(1));
        s   <= ADDR_WIDTH'(1);
        cnt <= CNT_W'(1);
        acc <= '0;
      end
      SEQ_STRIDE: begin
        in_stride[p_eff[idx]] <= s;
        s <= prod_s[ADDR_WIDTH-1:0];
        if (prod_c > LIM) begin
          cnt <= CNT_W'(LIM + CPRD_W'(1));
        end else begin
          cnt <= prod_c[CNT_W-1:0];
        end
        if (idx == '0) begin
          idx <= DIM_W'(rank - RANK_W'(1));
        end else begin
          idx <= idx - DIM_W'(1);
        end
      end
      SEQ_DELTA: begin
        delta[idx] <= in_stride[idx] - acc;
        acc <= acc + prod_d[ADDR_WIDTH-1:0];
        if (idx == '0) begin
          oversize <= cnt[ADDR_WIDTH] && (|cnt[ADDR_WIDTH-1:0]);
        end else begin
          idx <= idx - DIM_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign stat.busy     = (state != SEQ_IDLE);
  assign stat.oversize = oversize;

endmodule

/* sv/tensor_transpose_address_generator.sv */
// tensor_transpose_address_generator: top level, APB register file, coordinate
// counters, running address and result buffer. Uses tta_pkg, tta_ifs, tta_stride_unit.
//
//   port        | dir | beat
//   ------------+-----+-----------------------------------------------------
//   elem_in     | in  | element_value, one tensor element in row-major order
//   result_out  | out | out_index, moved_value, last_element, size_error
//   apb         | in  | rank_in_use, perm_order, dim_size_0..5 at 4*i
//
// One element per cycle while elem_in.ready is high; each result is registered before it appears on result_out.
// The running address steps by a precomputed per-dimension delta: one add per beat.
// After reset and after every register write the setup unit steps through its load, stride and delta states
// with elem_in.ready low; coordinates restart at zero.
// Output register plus skid stage: input keeps flowing for one beat of back-pressure.

module tensor_transpose_address_generator #(
  parameter int MAX_RANK   = tta_pkg::DEF_MAX_RANK,
  parameter int ADDR_WIDTH = tta_pkg::DEF_ADDR_WIDTH,
  parameter int ELEM_WIDTH = tta_pkg::DEF_ELEM_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  tta_elem_if.sink                       elem_in,
  tta_result_if.source                   result_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tta_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tta_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tta_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import tta_pkg::*;

  localparam int DIM_W  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int RANK_W = $clog2(MAX_RANK + 1);

  // configuration registers
  logic [RANK_REG_W-1:0] rank_reg;
  logic [PERM_REG_W-1:0] perm_reg;
  logic [EXT_W-1:0]      dim_size [NUM_DIM_REGS];
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;

  // streaming state
  logic [EXT_W-1:0]      coord [MAX_RANK];
  logic [ADDR_WIDTH-1:0] addr;
  logic [ADDR_WIDTH-1:0] addr_next;
  logic [ADDR_WIDTH-1:0] delta [MAX_RANK];
  setup_stat_t           stat;

  logic [RANK_W-1:0]  rank_eff;
  logic [PERM_FW-1:0] perm_field [MAX_RANK];
  logic [EXT_W-1:0]   ext [MAX_RANK];
  logic [MAX_RANK-1:0] wrap;
  logic [DIM_W-1:0]   step_dim;
  logic               found;
  logic               in_fire;
  logic               out_fire;

  // result buffer
  result_t res_new;
  result_t out_reg;
  result_t skid_reg;
  logic    out_valid;
  logic    skid_valid;

  // apb write and readback
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_reg <= RANK_RESET;
      perm_reg <= PERM_RESET;
      for (int i = 0; i < NUM_DIM_REGS; i++) begin
        dim_size[i] <= DIM_RESET;
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RANK: rank_reg    <= pwdata[RANK_REG_W-1:0];
        REG_PERM: perm_reg    <= pwdata[PERM_REG_W-1:0];
        REG_DIM0: dim_size[0] <= pwdata[EXT_W-1:0];
        REG_DIM1: dim_size[1] <= pwdata[EXT_W-1:0];
        REG_DIM2: dim_size[2] <= pwdata[EXT_W-1:0];
        REG_DIM3: dim_size[3] <= pwdata[EXT_W-1:0];
        REG_DIM4: dim_size[4] <= pwdata[EXT_W-1:0];
        REG_DIM5: dim_size[5] <= pwdata[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RANK: prdata = CFG_DATA_W'(rank_reg);
      REG_PERM: prdata = CFG_DATA_W'(perm_reg);
      REG_DIM0: prdata = CFG_DATA_W'(dim_size[0]);
      REG_DIM1: prdata = CFG_DATA_W'(dim_size[1]);
      REG_DIM2: prdata = CFG_DATA_W'(dim_size[2]);
      REG_DIM3: prdata = CFG_DATA_W'(dim_size[3]);
      REG_DIM4: prdata = CFG_DATA_W'(dim_size[4]);
      REG_DIM5: prdata = CFG_DATA_W'(dim_size[5]);
      default:  prdata = '0;
    endcase
  end

  // effective rank, zero counts as one and values above MAX_RANK clamp to MAX_RANK
  always_comb begin
    if (rank_reg == '0) begin
      rank_eff = RANK_W'(1);
    end else if (int'(rank_reg) > MAX_RANK) begin
      rank_eff = RANK_W'(MAX_RANK);
    end else begin
      rank_eff = RANK_W'(rank_reg);
    end
  end

  // effective extents and permutation fields per dimension
  for (genvar g = 0; g < MAX_RANK; g++) begin : g_dim
    if (g < NUM_DIM_REGS) begin : g_reg
      assign ext[g] = (dim_size[g] == '0) ? EXT_W'(1) : dim_size[g];
      assign perm_field[g] = perm_reg[PERM_FW*g +: PERM_FW];
    end else begin : g_unit
      assign ext[g] = EXT_W'(1);
      assign perm_field[g] = '0;
    end
  end

  tta_stride_unit #(
    .MAX_RANK   (MAX_RANK),
    .ADDR_WIDTH (ADDR_WIDTH),
    .DIM_W      (DIM_W),
    .RANK_W     (RANK_W)
  ) u_stride (
    .clk        (clk),
    .rst        (rst),
    .start      (cfg_wr),
    .rank       (rank_eff),
    .perm_field (perm_field),
    .ext        (ext),
    .delta      (delta),
    .stat       (stat)
  );

  // innermost dimension that does not wrap takes the step
  always_comb begin
    found    = 1'b0;
    step_dim = '0;
    for (int i = 0; i < MAX_RANK; i++) begin
      wrap[i] = ({1'b0, coord[i]} + (EXT_W + 1)'(1)) >= {1'b0, ext[i]};
      if (i < rank_eff && !wrap[i]) begin
        found    = 1'b1;
        step_dim = DIM_W'(i);
      end
    end
    addr_next = found ? (addr + delta[step_dim]) : '0;
  end

  assign in_fire  = elem_in.valid && elem_in.ready;
  assign out_fire = out_valid && result_out.ready;
  assign elem_in.ready = !skid_valid && !stat.busy;

  // coordinate counters and running address
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      addr <= '0;
      for (int i = 0; i < MAX_RANK; i++) begin
        coord[i] <= '0;
      end
    end else if (in_fire) begin
      addr <= addr_next;
      for (int i = 0; i < MAX_RANK; i++) begin
        if (!found || i > step_dim) begin
          coord[i] <= '0;
        end else if (i == step_dim) begin
          coord[i] <= coord[i] + EXT_W'(1);
        end
      end
    end
  end

  // result beat for the element being taken
  always_comb begin
    res_new.out_index    = INDEX_PORT_W'(addr);
    res_new.moved_value  = ELEM_PORT_W'(elem_in.element_value[ELEM_WIDTH-1:0]);
    res_new.last_element = !found;
    res_new.size_error   = stat.oversize;
  end

  // output register and skid valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!in_fire) begin
        out_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  // output register and skid payload
  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (in_fire) begin
        out_reg <= res_new;
      end
    end else if (in_fire) begin
      if (out_valid) begin
        skid_reg <= res_new;
      end else begin
        out_reg <= res_new;
      end
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.out_index    = out_reg.out_index;
  assign result_out.moved_value  = out_reg.moved_value;
  assign result_out.last_element = out_reg.last_element;
  assign result_out.size_error   = out_reg.size_error;

  // a register write always kicks off a setup sweep
  a_write_starts_setup: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> stat.busy)
    else $error("setup unit not busy after register write");

  // after the final element the running address restarts at zero
  a_last_clears_addr: assert property (@(posedge clk) disable iff (rst)
    in_fire && !found && !cfg_wr |=> addr == '0)
    else $error("running address not cleared after last element");

  // the skid stage only holds a beat behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full with output register empty");

endmodule
